>>> sv/bmr_pkg.sv
// ----------------------------------------------------------------------------
// bmr_pkg
// shared types and constants of the bitmap rectangle merger
// ----------------------------------------------------------------------------
`default_nettype none

package bmr_pkg;

    localparam int ROW_W   = 3;
    localparam int FIELD_W = 3;

    typedef struct packed {
        logic             final_row;
        logic [ROW_W-1:0] row;
    } t_span_hdr;

endpackage

`default_nettype wire

>>> sv/bmr_front.sv
// ----------------------------------------------------------------------------
// bmr_front
// accepts a bitmap row, splits it into spans and tags it with its glyph row
// ----------------------------------------------------------------------------
`default_nettype none

module bmr_front #(
    parameter int GLYPH_WIDTH  = 5,
    parameter int GLYPH_HEIGHT = 7,
    parameter int MAX_SPANS    = 3,
    parameter int CW           = $clog2(GLYPH_WIDTH + 1),
    parameter int NW           = $clog2(MAX_SPANS + 1)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_accept,
    input  wire logic [GLYPH_WIDTH-1:0]          i_row_bits,
    output logic      [MAX_SPANS-1:0][CW-1:0]    o_starts,
    output logic      [MAX_SPANS-1:0][CW-1:0]    o_ends,
    output logic      [NW-1:0]                   o_nspans,
    output bmr_pkg::t_span_hdr                   o_hdr
);

    localparam int SUM_W = bmr_pkg::ROW_W + 2;

    logic [bmr_pkg::ROW_W-1:0] r_row;
    logic [bmr_pkg::ROW_W-1:0] n_row;
    logic [SUM_W-1:0]          row_inc;
    logic                      final_row;
    logic [GLYPH_WIDTH-1:0]    col;
    logic [GLYPH_WIDTH:0]      col_prev;
    logic [GLYPH_WIDTH:0]      col_next;
    logic [GLYPH_WIDTH-1:0]    smask;
    logic [GLYPH_WIDTH-1:0]    emask;

    assign row_inc   = {2'b00, r_row} + SUM_W'(1);
    assign final_row = (row_inc >= SUM_W'(GLYPH_HEIGHT));
    assign n_row     = final_row ? '0 : row_inc[bmr_pkg::ROW_W-1:0];

    // column c is bit width-1-c
    always_comb begin
        for (int c = 0; c < GLYPH_WIDTH; c++) begin
            col[c] = i_row_bits[GLYPH_WIDTH-1-c];
        end
    end

    assign col_prev = {col, 1'b0};
    assign col_next = {1'b0, col};
    assign smask    = col & ~col_prev[GLYPH_WIDTH-1:0];
    assign emask    = col & ~col_next[GLYPH_WIDTH:1];

    always_comb begin
        o_starts = '0;
        o_ends   = '0;
        for (int c = 0; c < GLYPH_WIDTH; c++) begin
            for (int k = 0; k < MAX_SPANS; k++) begin
                if (smask[c] && ($countones(smask & ((GLYPH_WIDTH'(1) << c) - 1)) == k)) begin
                    o_starts[k] = CW'(c);
                end
                if (emask[c] && ($countones(emask & ((GLYPH_WIDTH'(1) << c) - 1)) == k)) begin
                    o_ends[k] = CW'(c + 1);
                end
            end
        end
        if ($countones(smask) > MAX_SPANS) begin
            o_nspans = NW'(MAX_SPANS);
        end else begin
            o_nspans = NW'($countones(smask));
        end
    end

    assign o_hdr.final_row = final_row;
    assign o_hdr.row       = r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else if (i_accept) begin
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

>>> sv/bmr_queue.sv
// ----------------------------------------------------------------------------
// bmr_queue
// two-entry queue between the span front end and the merge back end
// ----------------------------------------------------------------------------
`default_nettype none

module bmr_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic      [DATA_W-1:0] o_data,
    output logic                   o_valid
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wptr;
    logic              r_rptr;
    logic [1:0]        r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/bmr_back.sv
// ----------------------------------------------------------------------------
// bmr_back
// merges spans into open rectangles, drains closed ones one per cycle while popped
// ----------------------------------------------------------------------------
`default_nettype none

module bmr_back #(
    parameter int GLYPH_WIDTH  = 5,
    parameter int GLYPH_HEIGHT = 7,
    parameter int MAX_SPANS    = 3,
    parameter int CW           = $clog2(GLYPH_WIDTH + 1),
    parameter int NW           = $clog2(MAX_SPANS + 1)
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_q_valid,
    input  wire logic      [MAX_SPANS-1:0][CW-1:0]     i_q_starts,
    input  wire logic      [MAX_SPANS-1:0][CW-1:0]     i_q_ends,
    input  wire logic      [NW-1:0]                    i_q_nspans,
    input  wire bmr_pkg::t_span_hdr                    i_q_hdr,
    output logic                                       o_q_pop,
    output logic                                       o_empty,
    input  wire logic                                  i_pop,
    output logic      [bmr_pkg::FIELD_W-1:0]           o_left_col,
    output logic      [bmr_pkg::FIELD_W-1:0]           o_right_col_excl,
    output logic      [bmr_pkg::FIELD_W-1:0]           o_top_row,
    output logic      [bmr_pkg::FIELD_W-1:0]           o_bottom_row_excl,
    output logic                                       o_last_of_item,
    output logic                                       o_glyph_end
);

    localparam int FW    = bmr_pkg::FIELD_W;
    localparam int RW    = bmr_pkg::ROW_W;
    localparam int EMAX  = 2 * MAX_SPANS;
    localparam int EW    = $clog2(EMAX);
    localparam int CNT_W = $clog2(EMAX + 1);
    localparam int IW    = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
    localparam logic [FW-1:0] FLUSH_BOTTOM = FW'(GLYPH_HEIGHT);

    logic [CW-1:0]    r_open_l [MAX_SPANS];
    logic [CW-1:0]    r_open_r [MAX_SPANS];
    logic [RW-1:0]    r_open_t [MAX_SPANS];
    logic [NW-1:0]    r_open_cnt;
    logic [NW-1:0]    n_open_cnt;

    logic [FW-1:0]    r_em_l [EMAX];
    logic [FW-1:0]    r_em_r [EMAX];
    logic [FW-1:0]    r_em_t [EMAX];
    logic [FW-1:0]    r_em_b [EMAX];
    logic             r_em_g [EMAX];
    logic [CNT_W-1:0] r_em_cnt;
    logic [CNT_W-1:0] r_em_idx;

    logic [CW-1:0]    nx_l [MAX_SPANS];
    logic [CW-1:0]    nx_r [MAX_SPANS];
    logic [RW-1:0]    nx_t [MAX_SPANS];
    logic [FW-1:0]    em_l [EMAX];
    logic [FW-1:0]    em_r [EMAX];
    logic [FW-1:0]    em_t [EMAX];
    logic [FW-1:0]    em_b [EMAX];
    logic             em_g [EMAX];
    logic [CNT_W-1:0] n_em_cnt;

    logic             avail;
    logic             last_idx;
    logic             load;

    assign avail    = (r_em_idx != r_em_cnt);
    assign last_idx = (r_em_idx == (r_em_cnt - CNT_W'(1)));
    assign load     = i_q_valid && (!avail || (i_pop && last_idx));
    assign o_q_pop  = load;
    assign o_empty  = !avail;

    assign o_left_col        = r_em_l[r_em_idx[EW-1:0]];
    assign o_right_col_excl  = r_em_r[r_em_idx[EW-1:0]];
    assign o_top_row         = r_em_t[r_em_idx[EW-1:0]];
    assign o_bottom_row_excl = r_em_b[r_em_idx[EW-1:0]];
    assign o_glyph_end       = r_em_g[r_em_idx[EW-1:0]];
    assign o_last_of_item    = last_idx;

    always_comb begin
        logic [MAX_SPANS-1:0] matched;
        logic                 found;
        logic [NW-1:0]        nc;
        logic [CNT_W-1:0]     ec;
        matched = '0;
        found   = 1'b0;
        nc      = '0;
        ec      = '0;
        nx_l    = '{default: '0};
        nx_r    = '{default: '0};
        nx_t    = '{default: '0};
        em_l    = '{default: '0};
        em_r    = '{default: '0};
        em_t    = '{default: '0};
        em_b    = '{default: '0};
        em_g    = '{default: 1'b0};

        // carried rectangles take the first unmatched span with equal edges
        for (int i = 0; i < MAX_SPANS; i++) begin
            if (i < int'(r_open_cnt)) begin
                found = 1'b0;
                for (int j = 0; j < MAX_SPANS; j++) begin
                    if (!found && (j < int'(i_q_nspans)) && !matched[j] &&
                        (i_q_starts[j] == r_open_l[i]) && (i_q_ends[j] == r_open_r[i])) begin
                        matched[j] = 1'b1;
                        found      = 1'b1;
                    end
                end
                if (found) begin
                    nx_l[nc[IW-1:0]] = r_open_l[i];
                    nx_r[nc[IW-1:0]] = r_open_r[i];
                    nx_t[nc[IW-1:0]] = r_open_t[i];
                    nc = nc + NW'(1);
                end else begin
                    em_l[ec[EW-1:0]] = FW'(r_open_l[i]);
                    em_r[ec[EW-1:0]] = FW'(r_open_r[i]);
                    em_t[ec[EW-1:0]] = FW'(r_open_t[i]);
                    em_b[ec[EW-1:0]] = FW'(i_q_hdr.row);
                    em_g[ec[EW-1:0]] = i_q_hdr.final_row;
                    ec = ec + CNT_W'(1);
                end
            end
        end

        // unmatched spans open new rectangles while open slots remain
        for (int j = 0; j < MAX_SPANS; j++) begin
            if ((j < int'(i_q_nspans)) && !matched[j] && (int'(nc) < MAX_SPANS)) begin
                nx_l[nc[IW-1:0]] = i_q_starts[j];
                nx_r[nc[IW-1:0]] = i_q_ends[j];
                nx_t[nc[IW-1:0]] = i_q_hdr.row;
                nc = nc + NW'(1);
            end
        end

        // flush on the final row
        if (i_q_hdr.final_row) begin
            for (int i = 0; i < MAX_SPANS; i++) begin
                if (i < int'(nc)) begin
                    em_l[ec[EW-1:0]] = FW'(nx_l[i]);
                    em_r[ec[EW-1:0]] = FW'(nx_r[i]);
                    em_t[ec[EW-1:0]] = FW'(nx_t[i]);
                    em_b[ec[EW-1:0]] = FLUSH_BOTTOM;
                    em_g[ec[EW-1:0]] = 1'b1;
                    ec = ec + CNT_W'(1);
                end
            end
            n_open_cnt = '0;
        end else begin
            n_open_cnt = nc;
        end
        n_em_cnt = ec;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_open_l <= nx_l;
            r_open_r <= nx_r;
            r_open_t <= nx_t;
            r_em_l   <= em_l;
            r_em_r   <= em_r;
            r_em_t   <= em_t;
            r_em_b   <= em_b;
            r_em_g   <= em_g;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_cnt <= '0;
            r_em_cnt   <= '0;
            r_em_idx   <= '0;
        end else if (load) begin
            r_open_cnt <= n_open_cnt;
            r_em_cnt   <= n_em_cnt;
            r_em_idx   <= '0;
        end else if (i_pop && avail) begin
            r_em_idx <= r_em_idx + CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

>>> sv/bitmap_rect_merger.sv
// path: an accepted row is written into the span queue and merged from it when the back end
// loads it; its first item is then on the result ports
// throughput: one row per cycle while each row emits at most one rectangle and pop is
// held; else a row waits while its rectangles drain via the back end's single result port
// reset: synchronous, clears the span queue, open list, result buffer and row
// counter at once; no clearing pass
// ----------------------------------------------------------------------------
// bitmap_rect_merger
// merges glyph bitmap rows into rectangles of set pixels
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_rect_merger #(
    parameter int GLYPH_WIDTH  = 5,
    parameter int GLYPH_HEIGHT = 7,
    parameter int MAX_SPANS    = 3
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [GLYPH_WIDTH-1:0]       i_row_bits,
    output logic                              empty,
    input  wire logic                         pop,
    output logic      [bmr_pkg::FIELD_W-1:0]  o_left_col,
    output logic      [bmr_pkg::FIELD_W-1:0]  o_right_col_excl,
    output logic      [bmr_pkg::FIELD_W-1:0]  o_top_row,
    output logic      [bmr_pkg::FIELD_W-1:0]  o_bottom_row_excl,
    output logic                              o_last_of_item,
    output logic                              o_glyph_end
);

    localparam int CW     = $clog2(GLYPH_WIDTH + 1);
    localparam int NW     = $clog2(MAX_SPANS + 1);
    localparam int HDR_W  = $bits(bmr_pkg::t_span_hdr);
    localparam int DATA_W = HDR_W + NW + 2 * MAX_SPANS * CW;

    logic                          accept;
    logic [MAX_SPANS-1:0][CW-1:0]  f_starts;
    logic [MAX_SPANS-1:0][CW-1:0]  f_ends;
    logic [NW-1:0]                 f_nspans;
    bmr_pkg::t_span_hdr            f_hdr;
    logic [DATA_W-1:0]             q_in;
    logic [DATA_W-1:0]             q_out;
    logic                          q_valid;
    logic                          q_pop;
    logic [MAX_SPANS-1:0][CW-1:0]  q_starts;
    logic [MAX_SPANS-1:0][CW-1:0]  q_ends;
    logic [NW-1:0]                 q_nspans;
    bmr_pkg::t_span_hdr            q_hdr;

    assign accept = push && !full;
    assign q_in   = {f_hdr, f_nspans, f_starts, f_ends};
    assign {q_hdr, q_nspans, q_starts, q_ends} = q_out;

    bmr_front #(
        .GLYPH_WIDTH  (GLYPH_WIDTH),
        .GLYPH_HEIGHT (GLYPH_HEIGHT),
        .MAX_SPANS    (MAX_SPANS),
        .CW           (CW),
        .NW           (NW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_row_bits (i_row_bits),
        .o_starts   (f_starts),
        .o_ends     (f_ends),
        .o_nspans   (f_nspans),
        .o_hdr      (f_hdr)
    );

    bmr_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (q_in),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_valid (q_valid)
    );

    bmr_back #(
        .GLYPH_WIDTH  (GLYPH_WIDTH),
        .GLYPH_HEIGHT (GLYPH_HEIGHT),
        .MAX_SPANS    (MAX_SPANS),
        .CW           (CW),
        .NW           (NW)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_starts        (q_starts),
        .i_q_ends          (q_ends),
        .i_q_nspans        (q_nspans),
        .i_q_hdr           (q_hdr),
        .o_q_pop           (q_pop),
        .o_empty           (empty),
        .i_pop             (pop),
        .o_left_col        (o_left_col),
        .o_right_col_excl  (o_right_col_excl),
        .o_top_row         (o_top_row),
        .o_bottom_row_excl (o_bottom_row_excl),
        .o_last_of_item    (o_last_of_item),
        .o_glyph_end       (o_glyph_end)
    );

endmodule

`default_nettype wire

>>> sv/bmr_checker.sv
// ----------------------------------------------------------------------------
// bmr_checker
// port-level checks of the bitmap rectangle merger
// ----------------------------------------------------------------------------
`default_nettype none

module bmr_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        push,
    input wire logic                        full,
    input wire logic                        empty,
    input wire logic                        pop,
    input wire logic [bmr_pkg::FIELD_W-1:0] o_left_col,
    input wire logic [bmr_pkg::FIELD_W-1:0] o_right_col_excl,
    input wire logic [bmr_pkg::FIELD_W-1:0] o_top_row,
    input wire logic [bmr_pkg::FIELD_W-1:0] o_bottom_row_excl,
    input wire logic                        o_last_of_item,
    input wire logic                        o_glyph_end
);

    // reset leaves both queue sides idle
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("not idle after reset");

    // the input side fills only on a pushed item
    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!full && !push) |=> !full)
        else $error("full rose without a push");

    // a stalled item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_left_col) && $stable(o_right_col_excl) &&
            $stable(o_top_row) && $stable(o_bottom_row_excl) &&
            $stable(o_last_of_item) && $stable(o_glyph_end)))
        else $error("stalled item changed");

    // more items of the same row follow without a gap
    a_row_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_of_item) |=> !empty)
        else $error("gap inside one row's items");

    // once set, the glyph-end flag stays set through the rest of a row's items
    a_gend_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_of_item && o_glyph_end) |=> o_glyph_end)
        else $error("glyph end flag dropped inside a row");

endmodule

bind bitmap_rect_merger bmr_checker u_bmr_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .push              (push),
    .full              (full),
    .empty             (empty),
    .pop               (pop),
    .o_left_col        (o_left_col),
    .o_right_col_excl  (o_right_col_excl),
    .o_top_row         (o_top_row),
    .o_bottom_row_excl (o_bottom_row_excl),
    .o_last_of_item    (o_last_of_item),
    .o_glyph_end       (o_glyph_end)
);

`default_nettype wire

>>> verif/tb_bitmap_rect_merger.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_rect_merger
// feeds glyph rows into the merger in bursts with random gaps, stalls the
// result side on a rotating pattern, and checks every rectangle in order
// against a behavioral model of the span merge, row counter and flush
// ----------------------------------------------------------------------------
module tb_bitmap_rect_merger;

    localparam int ROW_WIDTH    = 5;
    localparam int GLYPH_ROWS   = 7;
    localparam int SPAN_SLOTS   = 3;
    localparam int FW           = bmr_pkg::FIELD_W;
    localparam int RANDOM_GLYPHS = 63;
    localparam int RUN_LIMIT_NS = 2_000_000;

    typedef enum int {
        STYLE_NOISE,
        STYLE_BLOCKY,
        STYLE_SPARSE
    } t_glyph_style;

    typedef struct packed {
        logic [FW-1:0] left_col;
        logic [FW-1:0] right_col_excl;
        logic [FW-1:0] top_row;
    } t_open_rect;

    typedef struct packed {
        logic [FW-1:0] left_col;
        logic [FW-1:0] right_col_excl;
        logic [FW-1:0] top_row;
        logic [FW-1:0] bottom_row_excl;
        logic          last_of_item;
        logic          glyph_end;
    } t_rect_item;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 push       = 1'b0;
    logic [ROW_WIDTH-1:0] i_row_bits = '0;
    logic                 pop        = 1'b0;
    logic                 full;
    logic                 empty;
    logic [FW-1:0]        o_left_col;
    logic [FW-1:0]        o_right_col_excl;
    logic [FW-1:0]        o_top_row;
    logic [FW-1:0]        o_bottom_row_excl;
    logic                 o_last_of_item;
    logic                 o_glyph_end;

    t_open_rect open_rects [SPAN_SLOTS];
    logic [1:0] open_count = '0;
    logic [2:0] row_count  = '0;
    t_rect_item pending_rects [$];
    int         errors     = 0;
    int         burst_left = 0;
    logic [7:0] stall_phase = '0;

    bitmap_rect_merger #(
        .GLYPH_WIDTH  (ROW_WIDTH),
        .GLYPH_HEIGHT (GLYPH_ROWS),
        .MAX_SPANS    (SPAN_SLOTS)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_row_bits        (i_row_bits),
        .empty             (empty),
        .pop               (pop),
        .o_left_col        (o_left_col),
        .o_right_col_excl  (o_right_col_excl),
        .o_top_row         (o_top_row),
        .o_bottom_row_excl (o_bottom_row_excl),
        .o_last_of_item    (o_last_of_item),
        .o_glyph_end       (o_glyph_end)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // splits one row into spans and updates the open list, queuing the rectangles it closes
    function automatic void merge_row(input logic [ROW_WIDTH-1:0] bits);
        logic [FW-1:0] span_left  [SPAN_SLOTS];
        logic [FW-1:0] span_right [SPAN_SLOTS];
        bit            matched    [SPAN_SLOTS];
        t_open_rect    carried    [SPAN_SLOTS];
        t_rect_item    closed [$];
        int            n_spans;
        int            n_carried;
        int            col;
        int            start;
        int            hit;
        int            i;
        int            j;
        bit            last_row;
        n_spans   = 0;
        n_carried = 0;
        col       = 0;
        last_row  = (int'(row_count) + 1 >= GLYPH_ROWS);
        while (col < ROW_WIDTH) begin
            if (!bits[ROW_WIDTH-1-col]) begin
                col++;
            end else begin
                start = col;
                while (col < ROW_WIDTH && bits[ROW_WIDTH-1-col])
                    col++;
                if (n_spans < SPAN_SLOTS) begin
                    span_left[n_spans]  = FW'(start);
                    span_right[n_spans] = FW'(col);
                    n_spans++;
                end
            end
        end
        for (j = 0; j < SPAN_SLOTS; j++)
            matched[j] = 1'b0;
        for (i = 0; i < int'(open_count); i++) begin
            hit = -1;
            for (j = 0; j < n_spans; j++) begin
                if (hit < 0 && !matched[j] && span_left[j] == open_rects[i].left_col &&
                    span_right[j] == open_rects[i].right_col_excl)
                    hit = j;
            end
            if (hit >= 0) begin
                matched[hit] = 1'b1;
                carried[n_carried] = open_rects[i];
                n_carried++;
            end else begin
                closed.push_back(t_rect_item'{open_rects[i].left_col,
                    open_rects[i].right_col_excl, open_rects[i].top_row, row_count,
                    1'b0, last_row});
            end
        end
        for (j = 0; j < n_spans; j++) begin
            if (!matched[j] && n_carried < SPAN_SLOTS) begin
                carried[n_carried] = t_open_rect'{span_left[j], span_right[j], row_count};
                n_carried++;
            end
        end
        if (last_row) begin
            for (i = 0; i < n_carried; i++)
                closed.push_back(t_rect_item'{carried[i].left_col, carried[i].right_col_excl,
                    carried[i].top_row, FW'(GLYPH_ROWS), 1'b0, 1'b1});
            open_count = '0;
            row_count  = '0;
        end else begin
            for (i = 0; i < n_carried; i++)
                open_rects[i] = carried[i];
            open_count = 2'(n_carried);
            row_count  = row_count + 3'd1;
        end
        if (closed.size() > 0)
            closed[closed.size()-1].last_of_item = 1'b1;
        foreach (closed[k])
            pending_rects.push_back(closed[k]);
    endfunction

    task automatic send_row(input logic [ROW_WIDTH-1:0] bits);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(30, 60);
            else
                burst_left = $urandom_range(1, 10);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        push       <= 1'b1;
        i_row_bits <= bits;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        merge_row(bits);
    endtask

    task automatic wait_drained();
        push       <= 1'b0;
        burst_left = 0;
        while (pending_rects.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_empty_glyph();
        repeat (GLYPH_ROWS) send_row('0);
    endtask

    task automatic test_edge_shapes();
        send_row(5'b11111);
        send_row(5'b10101);
        send_row(5'b10101);
        send_row(5'b01110);
        send_row(5'b10001);
        send_row(5'b10001);
        send_row(5'b00100);
    endtask

    task automatic test_drain_pause();
        send_row(5'b11111);
        send_row(5'b11111);
        send_row(5'b10001);
        wait_drained();
        send_row(5'b00100);
        send_row(5'b01010);
        send_row(5'b01010);
        send_row(5'b00001);
        wait_drained();
    endtask

    task automatic test_random_glyphs(input int n_glyphs);
        logic [ROW_WIDTH-1:0] row;
        t_glyph_style         style;
        int                   pick;
        for (int g = 0; g < n_glyphs; g++) begin
            pick  = $urandom_range(0, 3);
            style = (pick == 0) ? STYLE_NOISE : (pick == 3) ? STYLE_SPARSE : STYLE_BLOCKY;
            row   = ROW_WIDTH'($urandom);
            for (int r = 0; r < GLYPH_ROWS; r++) begin
                case (style)
                    STYLE_NOISE: begin
                        row = ROW_WIDTH'($urandom);
                    end
                    STYLE_BLOCKY: begin
                        if (r > 0 && $urandom_range(0, 9) >= 7)
                            row = ROW_WIDTH'($urandom);
                    end
                    default: begin
                        row = ROW_WIDTH'($urandom & $urandom);
                    end
                endcase
                send_row(row);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_rect_item want;
        t_rect_item got;
        got = t_rect_item'{o_left_col, o_right_col_excl, o_top_row, o_bottom_row_excl,
                           o_last_of_item, o_glyph_end};
        if (i_rst_n && pop && !empty) begin
            if (pending_rects.size() == 0) begin
                $display("%0t: unexpected item: expected none, ", $time,
                         "actual l=%0d r=%0d t=%0d b=%0d last=%0b end=%0b",
                         got.left_col, got.right_col_excl, got.top_row,
                         got.bottom_row_excl, got.last_of_item, got.glyph_end);
                errors++;
            end else begin
                want = pending_rects.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch: ", $time,
                             "expected l=%0d r=%0d t=%0d b=%0d last=%0b end=%0b, ",
                             want.left_col, want.right_col_excl, want.top_row,
                             want.bottom_row_excl, want.last_of_item, want.glyph_end,
                             "actual l=%0d r=%0d t=%0d b=%0d last=%0b end=%0b",
                             got.left_col, got.right_col_excl, got.top_row,
                             got.bottom_row_excl, got.last_of_item, got.glyph_end);
                    errors++;
                end
            end
        end
        stall_phase <= stall_phase + 8'd1;
        case (stall_phase[7:6])
            2'd0:    pop <= 1'b1;
            2'd1:    pop <= 1'($urandom_range(0, 1));
            2'd2:    pop <= (stall_phase[1:0] != 2'd0);
            default: pop <= stall_phase[2];
        endcase
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_glyph();
        test_edge_shapes();
        test_drain_pause();
        test_random_glyphs(RANDOM_GLYPHS);
        push <= 1'b0;
        while (pending_rects.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
sv/bmr_pkg.sv
sv/bmr_front.sv
sv/bmr_queue.sv
sv/bmr_back.sv
sv/bitmap_rect_merger.sv
sv/bmr_checker.sv
verif/tb_bitmap_rect_merger.sv
